>>> src/wsmfe_pkg.sv
package wsmfe_pkg;

  localparam logic [7:0] HDR_TEXT_FINAL = 8'h81;
  localparam logic [7:0] LEN_MASKED_BIT = 8'h80;
  localparam logic [7:0] LEN_EXT16      = 8'd126;
  localparam int unsigned MASK_SIZE     = 4;

  // Output sequence slots; the short length form skips the two extended length slots.
  typedef enum logic [3:0] {
    SLOT_HDR    = 4'd0,
    SLOT_LEN    = 4'd1,
    SLOT_LEN_HI = 4'd2,
    SLOT_LEN_LO = 4'd3,
    SLOT_KEY0   = 4'd4,
    SLOT_KEY1   = 4'd5,
    SLOT_KEY2   = 4'd6,
    SLOT_KEY3   = 4'd7,
    SLOT_PAY    = 4'd8
  } slot_t;

  typedef struct packed {
    logic [7:0]  len_byte;
    logic [15:0] len;
    logic [31:0] key;
    logic [7:0]  pay;
    logic        eof;
    logic        len_short;
  } job_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = key[7:0];
      2'd1: b = key[15:8];
      2'd2: b = key[23:16];
      default: b = key[31:24];
    endcase
    return b;
  endfunction

endpackage

>>> src/websocket_masked_frame_encoder.sv
// Masked WebSocket client text frame encoder. Each accepted payload byte
// gives one masked output byte; the byte that opens a frame (start_of_frame
// with a nonzero length) is preceded by 0x81, the length byte(s) and the four
// key bytes, so it gives 7 output bytes (length under 126) or 9 output
// bytes (16-bit length form). Other payload bytes give one byte each, so a
// frame of N bytes gives N+6 or N+8 output bytes, all through the single
// byte-wide output register: a job register holds the current transaction's
// bytes while the next input is taken as the job's last byte leaves. Bytes
// outside an open frame and zero-length starts give no output at all.
module websocket_masked_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_start_of_frame,
  input  logic [15:0] in_frame_length,
  input  logic [31:0] in_mask_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_end_of_frame,
  output logic        out_last
);
  import wsmfe_pkg::*;

  // frame state
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [15:0] left_r, left_nxt;
  logic        open_r, open_nxt;

  // job register
  logic        job_valid_r, job_valid_nxt;
  slot_t       job_pos_r, job_pos_nxt;
  job_t        job_r, job_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_eof_r, out_eof_nxt;
  logic        out_last_r, out_last_nxt;

  logic        accept, accept_job, emit, emit_final;
  logic [7:0]  slot_byte;

  assign emit       = job_valid_r && (!out_valid_r || !out_stall);
  assign emit_final = emit && (job_pos_r == SLOT_PAY);
  assign in_stall   = job_valid_r && !emit_final;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    unique case (job_pos_r)
      SLOT_HDR:    slot_byte = HDR_TEXT_FINAL;
      SLOT_LEN:    slot_byte = job_r.len_byte;
      SLOT_LEN_HI: slot_byte = job_r.len[15:8];
      SLOT_LEN_LO: slot_byte = job_r.len[7:0];
      SLOT_KEY0, SLOT_KEY1, SLOT_KEY2, SLOT_KEY3:
        slot_byte = key_byte(job_r.key, job_pos_r[1:0]);
      default:     slot_byte = job_r.pay;
    endcase
  end

  always_comb begin
    logic [31:0] key_e;
    logic [1:0]  idx_e;
    logic [15:0] left_e;
    logic        open_e;
    logic [15:0] left_dec;

    key_e  = key_r;
    idx_e  = idx_r;
    left_e = left_r;
    open_e = open_r;
    if (in_start_of_frame) begin
      idx_e  = 2'd0;
      left_e = in_frame_length;
      open_e = (in_frame_length != 16'd0);
      if (in_frame_length != 16'd0) begin
        key_e = in_mask_key;
      end
    end
    left_dec = left_e - 16'd1;

    key_nxt  = key_r;
    idx_nxt  = idx_r;
    left_nxt = left_r;
    open_nxt = open_r;
    accept_job = 1'b0;
    if (accept) begin
      key_nxt  = key_e;
      idx_nxt  = idx_e;
      left_nxt = left_e;
      open_nxt = open_e;
      if (open_e) begin
        accept_job = 1'b1;
        idx_nxt  = idx_e + 2'd1;
        left_nxt = left_dec;
        open_nxt = (left_dec != 16'd0);
      end
    end

    job_nxt.len_short = in_frame_length < {8'h00, LEN_EXT16};
    job_nxt.len_byte  = job_nxt.len_short ? (LEN_MASKED_BIT | in_frame_length[7:0])
                                          : (LEN_MASKED_BIT | LEN_EXT16);
    job_nxt.len       = in_frame_length;
    job_nxt.key       = key_e;
    job_nxt.pay       = in_payload_byte ^ key_byte(key_e, idx_e);
    job_nxt.eof       = (left_dec == 16'd0);
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_pos_nxt   = job_pos_r;
    if (emit) begin
      if (job_pos_r == SLOT_PAY) begin
        job_valid_nxt = 1'b0;
      end else if (job_pos_r == SLOT_LEN && job_r.len_short) begin
        job_pos_nxt = SLOT_KEY0;
      end else begin
        job_pos_nxt = slot_t'(job_pos_r + 4'd1);
      end
    end
    if (accept_job) begin
      job_valid_nxt = 1'b1;
      job_pos_nxt   = in_start_of_frame ? SLOT_HDR : SLOT_PAY;
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_eof_nxt   = out_eof_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = slot_byte;
      out_eof_nxt   = (job_pos_r == SLOT_PAY) && job_r.eof;
      out_last_nxt  = (job_pos_r == SLOT_PAY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      idx_r       <= '0;
      left_r      <= '0;
      open_r      <= 1'b0;
      job_valid_r <= 1'b0;
      job_pos_r   <= SLOT_HDR;
      out_valid_r <= 1'b0;
    end else begin
      key_r       <= key_nxt;
      idx_r       <= idx_nxt;
      left_r      <= left_nxt;
      open_r      <= open_nxt;
      job_valid_r <= job_valid_nxt;
      job_pos_r   <= job_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_job) begin
      job_r <= job_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_eof_r  <= out_eof_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_out_byte     = out_byte_r;
  assign out_end_of_frame = out_eof_r;
  assign out_last         = out_last_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wsmfe_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       last;
  } stream_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_payload_byte;
  logic        in_start_of_frame;
  logic [15:0] in_frame_length;
  logic [31:0] in_mask_key;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_out_byte;
  logic        out_end_of_frame;
  logic        out_last;

  idle_mode_t idle_mode;

  // Frame encoder predictor: expected output bytes per accepted transaction.
  class frame_scoreboard;
    logic [31:0]  key_reg;
    logic [1:0]   key_pos;
    logic [15:0]  remaining;
    bit           open;
    stream_byte_t masked_stream_q[$];
    int           errors;

    function new();
      key_reg   = '0;
      key_pos   = '0;
      remaining = '0;
      open      = 1'b0;
      errors    = 0;
    endfunction

    function void push_byte(logic [7:0] data, logic eof, logic last);
      stream_byte_t sb;
      sb.data = data;
      sb.eof  = eof;
      sb.last = last;
      masked_stream_q.push_back(sb);
    endfunction

    function void note_input(logic [7:0] pb, logic sof, logic [15:0] flen, logic [31:0] key);
      logic [7:0] kb;
      if (sof) begin
        open = 1'b0;
        key_pos = '0;
        if (flen == 16'd0) begin
          remaining = '0;
          return;
        end
        key_reg   = key;
        remaining = flen;
        open      = 1'b1;
        push_byte(HDR_TEXT_FINAL, 1'b0, 1'b0);
        if (flen < 16'(LEN_EXT16)) begin
          push_byte(LEN_MASKED_BIT | flen[7:0], 1'b0, 1'b0);
        end else begin
          push_byte(LEN_MASKED_BIT | LEN_EXT16, 1'b0, 1'b0);
          push_byte(flen[15:8], 1'b0, 1'b0);
          push_byte(flen[7:0], 1'b0, 1'b0);
        end
        for (int i = 0; i < MASK_SIZE; i++)
          push_byte(key_reg[8*i +: 8], 1'b0, 1'b0);
      end
      if (!open)
        return;
      kb = key_reg[8*key_pos +: 8];
      key_pos = key_pos + 2'd1;
      remaining = remaining - 16'd1;
      if (remaining == 16'd0)
        open = 1'b0;
      // payload byte is always the final output of its transaction
      push_byte(pb ^ kb, remaining == 16'd0, 1'b1);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic eof, logic last);
      stream_byte_t exp;
      if (masked_stream_q.size() == 0) begin
        report($sformatf("unexpected byte %02h", data));
        return;
      end
      exp = masked_stream_q.pop_front();
      if (data !== exp.data)
        report($sformatf("out_byte %02h, expected %02h", data, exp.data));
      if (eof !== exp.eof)
        report($sformatf("end_of_frame %b, expected %b", eof, exp.eof));
      if (last !== exp.last)
        report($sformatf("last %b, expected %b", last, exp.last));
    endtask

    function int pending();
      return masked_stream_q.size();
    endfunction
  endclass

  frame_scoreboard sb = new();

  websocket_masked_frame_encoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_payload_byte   (in_payload_byte),
    .in_start_of_frame (in_start_of_frame),
    .in_frame_length   (in_frame_length),
    .in_mask_key       (in_mask_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_end_of_frame  (out_end_of_frame),
    .out_last          (out_last)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit roll_idle(bit sender);
    int r;
    r = $urandom_range(99);
    case (idle_mode)
      IDLE_SENDER:   return sender ? (r < 84) : 1'b0;
      IDLE_RECEIVER: return sender ? 1'b0 : (r < 84);
      IDLE_BOTH:     return r < 30;
      default:       return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin
    out_stall <= rst_n ? roll_idle(1'b0) : 1'b0;
  end

  // both transaction monitors sample at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_input(in_payload_byte, in_start_of_frame, in_frame_length, in_mask_key);
      if (out_valid && !out_stall)
        sb.check_result(out_out_byte, out_end_of_frame, out_last);
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task send_item(input logic [7:0] pb, input logic sof, input logic [15:0] flen,
                 input logic [31:0] key);
    while (roll_idle(1'b1)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_payload_byte   <= pb;
    in_start_of_frame <= sof;
    in_frame_length   <= flen;
    in_mask_key       <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // first byte opens the frame; later bytes carry junk in the sampled-on-start fields
  task send_frame(input logic [15:0] flen, input int nbytes);
    logic [31:0] key;
    key = $urandom;
    for (int k = 0; k < nbytes; k++) begin
      if (k == 0)
        send_item(8'($urandom_range(255)), 1'b1, flen, key);
      else
        send_item(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)), $urandom);
    end
  endtask

  task send_noise(input int nbytes);
    for (int k = 0; k < nbytes; k++)
      send_item(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)), $urandom);
  endtask

  initial begin
    int items;
    int pick;
    int flen;
    int n;
    idle_mode         = IDLE_NONE;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_payload_byte   = '0;
    in_start_of_frame = 1'b0;
    in_frame_length   = '0;
    in_mask_key       = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: dropped byte, zero-length start, single-byte frames at key extremes
    send_item(8'hFF, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(8'h00, 1'b1, 16'd0, 32'hDEAD_BEEF);
    send_item(8'h00, 1'b1, 16'd1, 32'hFFFF_FFFF);
    send_item(8'hFF, 1'b1, 16'd1, 32'h0000_0000);
    // longest short length, abandoned by the 16-bit form, then by the maximum length
    send_frame(16'd125, 2);
    send_frame(16'd126, 3);
    send_item(8'hFF, 1'b1, 16'hFFFF, 32'hA5C3_3C5A);
    send_noise(4);
    // zero-length start abandons the open frame; next byte is dropped
    send_item(8'h55, 1'b1, 16'd0, 32'h1234_5678);
    send_item(8'hAA, 1'b0, 16'd7, 32'h0);
    send_frame(16'd5, 5);

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_t'(ph);
      items = 0;
      while (items < 25) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          flen = $urandom_range(1, 12);
          send_frame(16'(flen), flen);
          items += flen;
        end else if (pick < 72) begin
          flen = $urandom_range(126, 65535);
          n = $urandom_range(1, 6);
          send_frame(16'(flen), n);
          items += n;
        end else if (pick < 79) begin
          flen = $urandom_range(2, 125);
          n = $urandom_range(1, (flen - 1 < 6) ? flen - 1 : 6);
          send_frame(16'(flen), n);
          items += n;
        end else if (pick < 84) begin
          flen = $urandom_range(13, 30);
          send_frame(16'(flen), flen);
          items += flen;
        end else if (pick < 93) begin
          send_noise($urandom_range(1, 3));
        end else begin
          send_item(8'($urandom_range(255)), 1'b1, 16'd0, $urandom);
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> files.f
src/wsmfe_pkg.sv
src/websocket_masked_frame_encoder.sv
tb/tb_top.sv
